// File: rtl/csq_pkg.sv
// Package: shared constants, request codes, controller types for the circular slot queue.
package csq_pkg;

  localparam int MAX_SLOTS  = 16;
  localparam int SLOT_BYTES = 8;
  localparam int DATA_W     = 64;
  localparam int CNT_W      = 5;
  localparam int IDX_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // Low SLOT_BYTES bytes of a slot are kept
  localparam logic [DATA_W-1:0] DATA_MASK = {DATA_W{1'b1}} >> (DATA_W - 8 * SLOT_BYTES);

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_PEEK    = 2'd2,
    REQ_QUERY   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } csq_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;      // accept a request beat: update state, access storage
    logic load_out;  // move the pending result into the output register
  } csq_cmd_t;

endpackage

// File: rtl/csq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/csq_ctrl.sv
// Controller: request/result handshake state machine for the circular slot queue.
module csq_ctrl
  import csq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output csq_cmd_t cmd
);

  csq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Decode commands and next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.exec      = 1'b0;
    cmd.load_out  = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/csq_dp.sv
// Datapath: ring indices, capacity register, slot storage and result registers.
module csq_dp
  import csq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  csq_cmd_t          cmd,
  input  logic [1:0]        in_req_type,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  output logic              out_success,
  output logic [DATA_W-1:0] out_read_data,
  output logic [CNT_W-1:0]  out_free_slots,
  output logic [CNT_W-1:0]  out_used_slots
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

  logic [IDX_W-1:0] wi_r, wi_nxt, ri_r, ri_nxt;
  logic             ne_r, ne_nxt;
  logic [CNT_W-1:0] cap_r, cap_cfg;

  logic             ok_r, ok_nxt;
  logic             rd_sel_r, rd_sel_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] free_r;

  logic             out_success_r;
  logic [DATA_W-1:0] out_read_data_r;
  logic [CNT_W-1:0] out_free_r, out_used_r;

  logic [DATA_W-1:0] ram_rdata;
  logic [IDX_W-1:0]  wi_inc, ri_inc;
  logic              same_idx, full, empty;
  logic              enq_ok, deq_ok, peek_ok;
  req_type_t         kind;

  // Clamp a written slot count into 1..MAX_SLOTS
  assign cap_cfg = (cfg_wr_data == '0) ? CNT_W'(1) :
                   (cfg_wr_data > MAX_CNT) ? MAX_CNT : cfg_wr_data;

  // Wrapping increments
  assign wi_inc = (CNT_W'(wi_r) + CNT_W'(1) >= cap_r) ? '0 : wi_r + IDX_W'(1);
  assign ri_inc = (CNT_W'(ri_r) + CNT_W'(1) >= cap_r) ? '0 : ri_r + IDX_W'(1);

  // Decode request against ring state
  always_comb begin
    kind     = req_type_t'(in_req_type);
    same_idx = (wi_r == ri_r);
    full     = same_idx && ne_r;
    empty    = same_idx && !ne_r;
    enq_ok   = (kind == REQ_ENQUEUE) && !full;
    deq_ok   = (kind == REQ_DEQUEUE) && !empty;
    peek_ok  = (kind == REQ_PEEK) && !empty;

    case (kind)
      REQ_ENQUEUE: ok_nxt = !full;
      REQ_DEQUEUE: ok_nxt = !empty;
      REQ_PEEK:    ok_nxt = !empty;
      REQ_QUERY:   ok_nxt = 1'b1;
      default:     ok_nxt = 1'b1;
    endcase
    rd_sel_nxt = deq_ok || peek_ok;

    wi_nxt = enq_ok ? wi_inc : wi_r;
    ri_nxt = deq_ok ? ri_inc : ri_r;
    if (enq_ok) begin
      ne_nxt = 1'b1;
    end else if (deq_ok && (ri_inc == wi_r)) begin
      ne_nxt = 1'b0;
    end else begin
      ne_nxt = ne_r;
    end

    // Used count after the update
    if (wi_nxt == ri_nxt) begin
      used_nxt = ne_nxt ? cap_r : '0;
    end else if (wi_nxt > ri_nxt) begin
      used_nxt = CNT_W'(wi_nxt) - CNT_W'(ri_nxt);
    end else begin
      used_nxt = CNT_W'(wi_nxt) + cap_r - CNT_W'(ri_nxt);
    end
  end

  // Ring state and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r  <= '0;
      ri_r  <= '0;
      ne_r  <= 1'b0;
      cap_r <= MAX_CNT;
    end else if (cfg_wr_en) begin
      wi_r  <= '0;
      ri_r  <= '0;
      ne_r  <= 1'b0;
      cap_r <= cap_cfg;
    end else if (cmd.exec) begin
      wi_r <= wi_nxt;
      ri_r <= ri_nxt;
      ne_r <= ne_nxt;
    end
  end

  // Capture pending result fields
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r     <= ok_nxt;
      rd_sel_r <= rd_sel_nxt;
      used_r   <= used_nxt;
      free_r   <= cap_r - used_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_success_r   <= ok_r;
      out_read_data_r <= rd_sel_r ? ram_rdata : '0;
      out_free_r      <= free_r;
      out_used_r      <= used_r;
    end
  end

  assign out_success    = out_success_r;
  assign out_read_data  = out_read_data_r;
  assign out_free_slots = out_free_r;
  assign out_used_slots = out_used_r;

  // Slot storage: write on enqueue, read head on every accepted beat
  csq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.exec && enq_ok),
    .waddr (wi_r),
    .wdata (in_write_data & DATA_MASK),
    .re    (cmd.exec),
    .raddr (ri_r),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/circular_slot_queue.sv
// Result path: an accepted request takes the controller to ST_RESP, where the slot RAM read
// completes; once the output register is free it is loaded, out_valid rises and in_ready returns.
// A new request is taken while the previous result still waits in the output register.
// Reset (rst_n low, synchronous): queue empty, both indices zero, capacity 16, no result valid.
// Writing the slot count empties the queue; slot contents are undefined until enqueued.
// Top level: circular queue of fixed-size slots with enqueue, dequeue, peek and count query.
module circular_slot_queue
  import csq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_success,
  output logic [DATA_W-1:0] out_read_data,
  output logic [CNT_W-1:0]  out_free_slots,
  output logic [CNT_W-1:0]  out_used_slots,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data
);

  csq_cmd_t cmd;

  csq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  csq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req_type    (in_req_type),
    .in_write_data  (in_write_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_success    (out_success),
    .out_read_data  (out_read_data),
    .out_free_slots (out_free_slots),
    .out_used_slots (out_used_slots)
  );

endmodule
